[rtl/core/mwlfo_pkg.sv]
package mwlfo_pkg;

  localparam int PHASE_BITS_DEF = 32;
  localparam int SINE_ENTRIES = 256;
  localparam int SINE_IDX_W = $clog2(SINE_ENTRIES);

  localparam int RATE_W = 12;
  localparam int LEVEL_W = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_ONE_SHOT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHAPE_CODE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_OFFSET = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_PERIODS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_LAW = 3'd4;

  typedef enum logic [4:0] {
    SH_RAMP     = 5'd0,
    SH_SAW      = 5'd1,
    SH_SQUARE   = 5'd2,
    SH_TRI      = 5'd3,
    SH_SINE     = 5'd4,
    SH_SINE2    = 5'd5,
    SH_SQUARE2  = 5'd6,
    SH_GATE1    = 5'd7,
    SH_GATE2    = 5'd8,
    SH_GATE3    = 5'd9,
    SH_GATE4    = 5'd10,
    SH_PULSE    = 5'd11,
    SH_QRAMP8   = 5'd12,
    SH_QRAMP4   = 5'd13,
    SH_QSAW8    = 5'd14,
    SH_QSAW4    = 5'd15,
    SH_ITRI     = 5'd16,
    SH_ISQUARE  = 5'd17,
    SH_IPULSE   = 5'd18,
    SH_TRI2     = 5'd19
  } shape_t;

  typedef struct packed {
    logic       one_shot;
    logic [4:0] shape_code;
    logic [1:0] phase_offset;
    logic       count_zero;
  } shape_ctl_t;

  typedef logic [SINE_ENTRIES-1:0][7:0] sine_tab_t;

  // offset-binary sine, rational approximation of one full turn
  function automatic sine_tab_t sine_build();
    sine_tab_t tab;
    int unsigned t;
    int unsigned p;
    int unsigned den;
    int unsigned num;
    int unsigned amp;
    for (int i = 0; i < SINE_ENTRIES; i++) begin
      t = i & 127;
      p = t * (128 - t);
      den = 81920 - 4 * p;
      num = 16 * p * 127 + (den >> 1);
      // rounded quotient by shift and subtract, it fits in 7 bits
      amp = 0;
      for (int b = 7; b >= 0; b--) begin
        if (num >= (den << b)) begin
          num = num - (den << b);
          amp = amp | (32'd1 << b);
        end
      end
      tab[i] = ((i & 128) != 0) ? 8'(128 - amp) : 8'(128 + amp);
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_ROM = sine_build();

endpackage

[rtl/core/mwlfo_shape.sv]
module mwlfo_shape (
  input  logic [31:0]             phase_al,
  input  mwlfo_pkg::shape_ctl_t   ctl,
  output logic [15:0]             level
);
  import mwlfo_pkg::*;

  localparam logic [31:0] LIM_1 = 32'h1FFF_FFFF;
  localparam logic [31:0] LIM_2 = 32'h3FFF_FFFF;
  localparam logic [31:0] LIM_3 = 32'h5FFF_FFFF;
  localparam logic [31:0] LIM_4 = 32'h7FFF_FFFF;
  localparam logic [31:0] LIM_5 = 32'h9FFF_FFFF;
  localparam logic [31:0] LIM_6 = 32'hBFFF_FFFF;
  localparam logic [31:0] LIM_7 = 32'hDFFF_FFFF;
  localparam logic [31:0] LIM_S2 = 32'hBFFF_FFFE;

  function automatic logic [15:0] tri_of(input logic [31:0] v);
    logic [31:0] f;
    f = v[31] ? ~v : v;
    return f[30:15];
  endfunction

  logic [31:0]           ac;
  logic [31:0]           d1;
  logic [31:0]           d2;
  logic [SINE_IDX_W-1:0] sine_idx;
  logic [15:0]           sine_val;
  logic [15:0]           free_lvl;
  logic [15:0]           os_lvl;
  logic                  gate_on;

  assign ac = ctl.one_shot ? phase_al : phase_al + {ctl.phase_offset, 30'd0};
  assign d1 = ac - LIM_4;
  assign d2 = ac - LIM_S2;

  always_comb begin
    if (shape_t'(ctl.shape_code) != SH_SINE2) begin
      sine_idx = ac[31:24];
    end else if (ac < LIM_4) begin
      sine_idx = {ac[30:24], 1'b0};
    end else if (ac < LIM_S2) begin
      sine_idx = {d1[29:24], 2'b00};
    end else begin
      sine_idx = {d2[29:24], 2'b00};
    end
  end

  assign sine_val = {SINE_ROM[sine_idx], 8'h00};

  assign gate_on = (ac < LIM_1) || (ac >= LIM_2 && ac < LIM_3) ||
                   (ac >= LIM_4 && ac < LIM_5) || (ac >= LIM_6 && ac < LIM_7);

  always_comb begin
    case (shape_t'(ctl.shape_code))
      SH_SAW:     free_lvl = ~ac[31:16];
      SH_SQUARE:  free_lvl = ac[31] ? 16'hFFFF : 16'h0000;
      SH_TRI:     free_lvl = tri_of(ac);
      SH_SINE,
      SH_SINE2:   free_lvl = sine_val;
      SH_SQUARE2: begin
        if (ac < LIM_2) free_lvl = 16'hFFFF;
        else if (ac < LIM_4) free_lvl = 16'h0000;
        else if (ac < LIM_5) free_lvl = 16'hFFFF;
        else if (ac < LIM_6) free_lvl = 16'h0000;
        else if (ac < LIM_7) free_lvl = 16'hFFFF;
        else free_lvl = 16'h0000;
      end
      SH_GATE1: begin
        if (ac < LIM_1) free_lvl = 16'hFFFF;
        else if (ac < LIM_2) free_lvl = 16'h0000;
        else if (ac < LIM_3) free_lvl = 16'hC000;
        else if (ac < LIM_4) free_lvl = 16'h4000;
        else if (ac < LIM_5) free_lvl = 16'hC000;
        else if (ac < LIM_6) free_lvl = 16'h4000;
        else if (ac < LIM_7) free_lvl = 16'hC000;
        else free_lvl = 16'h4000;
      end
      SH_GATE2: begin
        if (ac < LIM_2) free_lvl = 16'hFFFF;
        else if (ac < LIM_4) free_lvl = 16'h0000;
        else if (ac < LIM_6) free_lvl = 16'hC000;
        else free_lvl = 16'h4000;
      end
      SH_GATE3: begin
        if (ac < LIM_1) free_lvl = 16'hFFFF;
        else if (ac < LIM_2) free_lvl = 16'h0000;
        else if (ac < LIM_3) free_lvl = 16'hDFFF;
        else if (ac < LIM_4) free_lvl = 16'h2000;
        else if (ac < LIM_5) free_lvl = 16'hBFFF;
        else if (ac < LIM_6) free_lvl = 16'h4000;
        else if (ac < LIM_7) free_lvl = 16'h9FFF;
        else free_lvl = 16'h6000;
      end
      SH_GATE4:   free_lvl = gate_on ? ~ac[31:16] : 16'h0000;
      SH_PULSE:   free_lvl = (ac[31:30] != 2'b00) ? 16'hFFFF : 16'h0000;
      SH_QRAMP8:  free_lvl = 16'hE000 & ac[31:16];
      SH_QRAMP4:  free_lvl = 16'hC000 & ac[31:16];
      SH_QSAW8:   free_lvl = 16'hE000 & ~ac[31:16];
      SH_QSAW4:   free_lvl = 16'hC000 & ~ac[31:16];
      SH_ITRI:    free_lvl = ~tri_of(ac);
      SH_ISQUARE: free_lvl = ac[31] ? 16'h0000 : 16'hFFFF;
      SH_IPULSE:  free_lvl = (ac[31:30] != 2'b00) ? 16'h0000 : 16'hFFFF;
      default:    free_lvl = ac[31:16];
    endcase
  end

  always_comb begin
    case (shape_t'(ctl.shape_code))
      SH_TRI2:    os_lvl = ctl.count_zero ? tri_of(ac) : tri_of({ac[30:0], 1'b0});
      SH_SAW:     os_lvl = ~ac[31:16];
      SH_SQUARE:  os_lvl = ac[31] ? 16'hFFFF : 16'h0000;
      SH_TRI:     os_lvl = tri_of(ac);
      SH_PULSE:   os_lvl = (ac[31:30] != 2'b00) ? 16'hFFFF : 16'h0000;
      SH_QRAMP8:  os_lvl = 16'hFFF0 & ac[31:16];
      SH_QSAW8:   os_lvl = 16'hFFF0 & ~ac[31:16];
      SH_ITRI:    os_lvl = ~tri_of(ac);
      SH_ISQUARE: os_lvl = ac[31] ? 16'h0000 : 16'hFFFF;
      SH_IPULSE:  os_lvl = (ac[31:30] != 2'b00) ? 16'h0000 : 16'hFFFF;
      default:    os_lvl = ac[31:16];
    endcase
  end

  assign level = ctl.one_shot ? os_lvl : free_lvl;

endmodule

[rtl/core/multi_waveform_lfo.sv]
// Phase-accumulator LFO producing one result item per input item. An item with
// action 0 advances the phase by rate*8000+64 (or rate<<8 with rate_law set in
// free-running mode) and returns the selected waveform level, the wrap flag and
// the running flag, or level 0 without a phase step once a one-shot has stopped;
// an item with action 1 clears the phase, re-arms one-shot counting and repeats
// the last level. The block takes one item every clock cycle unless m_tready
// stalls the output. Items pass the input register (phase increment from the 12x13
// multiply), then the result register, fed by the phase add and waveform logic.
// The sine table is a constant ROM and needs no clearing after reset.
module multi_waveform_lfo #(
  parameter int PHASE_BITS = mwlfo_pkg::PHASE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [15:0]                     s_tdata,   // rate[11:0], zero pad
  input  logic                            s_tuser,   // action
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [15:0]                     m_tdata,   // level[15:0]
  output logic [1:0]                      m_tuser,   // wrapped, running
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mwlfo_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mwlfo_pkg::CFG_DATA_W-1:0] cfg_data
);
  import mwlfo_pkg::*;

  logic                  one_shot;
  logic [4:0]            shape_code;
  logic [1:0]            phase_offset;
  logic [7:0]            repeat_periods;
  logic                  rate_law;

  logic [PHASE_BITS-1:0] phase;
  logic [LEVEL_W-1:0]    held_level;
  logic                  active;
  logic [7:0]            period_count;

  logic                  a_valid;
  logic                  a_action;
  logic [PHASE_BITS-1:0] a_inc;

  logic                  out_valid;
  logic [LEVEL_W-1:0]    out_level;
  logic                  out_wrapped;
  logic                  out_running;

  logic                  b_adv;
  logic                  a_adv;
  logic [RATE_W-1:0]     in_rate;
  logic [24:0]           mul_sum;
  logic [31:0]           inc_wide;
  logic [PHASE_BITS:0]   sum;
  logic                  wrap;
  logic [PHASE_BITS-1:0] phase_next;
  logic [PHASE_BITS+31:0] al_wide;
  logic [31:0]           phase_al;
  logic [7:0]            pc_inc;
  logic                  stop;
  logic [7:0]            period_count_next;
  logic                  active_next;
  shape_ctl_t            ctl;
  logic [LEVEL_W-1:0]    shape_level;
  logic [LEVEL_W-1:0]    level_next;
  logic                  wrapped_next;
  logic                  running_next;

  assign cfg_ready = 1'b1;
  assign b_adv = !out_valid || m_tready;
  assign a_adv = a_valid && b_adv;
  assign s_tready = !a_valid || b_adv;

  assign in_rate = s_tdata[RATE_W-1:0];
  assign mul_sum = 25'(in_rate) * 25'd8000 + 25'd64;
  assign inc_wide = (!one_shot && rate_law) ? {12'd0, in_rate, 8'd0} : {7'd0, mul_sum};

  assign sum = {1'b0, phase} + {1'b0, a_inc};
  assign wrap = sum[PHASE_BITS];
  assign phase_next = sum[PHASE_BITS-1:0];
  assign al_wide = {phase_next, 32'd0};
  assign phase_al = al_wide[PHASE_BITS+31 -: 32];

  assign pc_inc = period_count + 8'd1;
  assign stop = wrap && (repeat_periods != 8'd0) && (pc_inc == repeat_periods);
  assign period_count_next = !wrap ? period_count : (stop ? 8'd0 : pc_inc);
  assign active_next = active && !stop;

  assign ctl.one_shot = one_shot;
  assign ctl.shape_code = shape_code;
  assign ctl.phase_offset = phase_offset;
  assign ctl.count_zero = (period_count_next == 8'd0);

  mwlfo_shape u_shape (
    .phase_al (phase_al),
    .ctl      (ctl),
    .level    (shape_level)
  );

  always_comb begin
    if (a_action) begin
      level_next = held_level;
      wrapped_next = 1'b0;
      running_next = 1'b1;
    end else if (one_shot && !active) begin
      level_next = '0;
      wrapped_next = 1'b0;
      running_next = 1'b0;
    end else begin
      level_next = shape_level;
      wrapped_next = wrap;
      running_next = one_shot ? active_next : 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      one_shot <= 1'b0;
      shape_code <= '0;
      phase_offset <= '0;
      repeat_periods <= 8'd1;
      rate_law <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ONE_SHOT:       one_shot <= cfg_data[0];
        CFG_SHAPE_CODE:     shape_code <= cfg_data[4:0];
        CFG_PHASE_OFFSET:   phase_offset <= cfg_data[1:0];
        CFG_REPEAT_PERIODS: repeat_periods <= cfg_data;
        CFG_RATE_LAW:       rate_law <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (s_tready) begin
      a_valid <= s_tvalid;
    end
    if (s_tvalid && s_tready) begin
      a_action <= s_tuser;
      a_inc <= inc_wide[PHASE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
      held_level <= '0;
      active <= 1'b1;
      period_count <= '0;
    end else if (a_adv) begin
      if (a_action) begin
        phase <= '0;
        active <= 1'b1;
        period_count <= '0;
      end else begin
        held_level <= level_next;
        if (!one_shot) begin
          phase <= phase_next;
        end else if (active) begin
          phase <= phase_next;
          period_count <= period_count_next;
          active <= active_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b_adv) begin
      out_valid <= a_valid;
    end
    if (a_adv) begin
      out_level <= level_next;
      out_wrapped <= wrapped_next;
      out_running <= running_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata = out_level;
  assign m_tuser = {out_running, out_wrapped};

`ifndef SYNTHESIS
  a_stopped_is_silent: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_running && !out_wrapped) |-> (out_level == '0))
    else $error("stopped item carries nonzero level");

  a_retrig_clears: assert property (@(posedge clk) disable iff (rst)
    (a_adv && a_action) |=> (phase == '0 && active && period_count == '0))
    else $error("retrigger did not clear phase state");

  a_input_loads: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> a_valid)
    else $error("accepted item lost at input register");
`endif

endmodule
